### design/hmlp_pkg.sv
// Shared types and constants for the linear-probe hash map.
// No dependencies; imported by every module of the block.
package hmlp_pkg;

  localparam int unsigned FuncW = 3;
  localparam int unsigned KeyW  = 64;
  localparam int unsigned ValW  = 32;
  localparam int unsigned SizeW = 11;

  // Right shift used by the key mixer before the salt multiply.
  localparam int unsigned MixShift = 33;

  localparam logic [63:0] SaltReset = 64'h9E37_79B9_7F4A_7C15;

  typedef enum logic [FuncW-1:0] {
    FUNC_SET   = 3'd0,
    FUNC_ADD   = 3'd1,
    FUNC_GET   = 3'd2,
    FUNC_ERASE = 3'd3,
    FUNC_CLEAR = 3'd4
  } hmlp_func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CHECK
  } hmlp_state_e;

  typedef struct packed {
    hmlp_func_e              func;
    logic [KeyW-1:0]         key;
    logic signed [ValW-1:0]  value_in;
  } hmlp_req_t;

  typedef struct packed {
    logic signed [ValW-1:0]  value_out;
    logic                    found;
    logic [SizeW-1:0]        size_now;
    logic                    table_full;
  } hmlp_rsp_t;

endpackage

### design/hmlp_hash.sv
// Home-slot hash: (key ^ key>>33) * salt, low index bits, registered.
// Depends on hmlp_pkg.
module hmlp_hash #(
  parameter int unsigned INDEX_BITS = 10,
  parameter int unsigned KEY_BITS   = 64
) (
  input  logic                  clk_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [INDEX_BITS-1:0] salt_i,
  output logic [INDEX_BITS-1:0] home_o
);
  import hmlp_pkg::*;

  logic [63:0]           key_wide;
  logic [63:0]           mix;
  logic [INDEX_BITS-1:0] home_d;
  logic [INDEX_BITS-1:0] home_q;

  // Only the low index bits of the product matter, so a narrow multiply suffices.
  always_comb begin
    key_wide = 64'(key_i);
    mix      = key_wide ^ (key_wide >> MixShift);
    home_d   = mix[INDEX_BITS-1:0] * salt_i;
  end

  always_ff @(posedge clk_i) begin
    home_q <= home_d;
  end

  assign home_o = home_q;

endmodule

### design/hmlp_slot_ram.sv
// Slot storage: one write port, one read port with registered read data.
// Depends on hmlp_pkg.
module hmlp_slot_ram #(
  parameter int unsigned ADDR_BITS = 10,
  parameter int unsigned DATA_BITS = 97
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);
  import hmlp_pkg::*;

  localparam int unsigned Depth = 2 ** ADDR_BITS;

  logic [DATA_BITS-1:0] mem_q [Depth];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/hash_map_linear_probe.sv
// Channel   | Signals                      | Transfer rule
// ----------+------------------------------+-------------------------------------
// request   | start, busy, req_i           | taken when start is high, busy low
// result    | done_o, rsp_o                | one-cycle strobe per result, no back-pressure
// config    | cfg_we_i, cfg_wdata_i        | hash salt written when cfg_we_i high
//
// An item holds busy through ST_HASH and then stays in ST_CHECK while slots are probed (one
// slot read and compared per cycle through the single RAM read port); an unused
// func code holds it through ST_HASH only. The result strobes in the same cycle that busy falls.
// After reset the valid bits are swept one slot per cycle with busy high; a clear
// is decoded in ST_HASH and then runs that sweep.
// Depends on hmlp_pkg, hmlp_hash, hmlp_slot_ram.
module hash_map_linear_probe #(
  parameter int unsigned INDEX_BITS = 10,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  hmlp_pkg::hmlp_req_t req_i,
  output logic              done_o,
  output hmlp_pkg::hmlp_rsp_t rsp_o,
  input  logic              cfg_we_i,
  input  logic [63:0]       cfg_wdata_i
);
  import hmlp_pkg::*;

  localparam int unsigned RowW   = 1 + KEY_BITS + VALUE_BITS;
  localparam int unsigned CountW = INDEX_BITS + 1;

  hmlp_state_e state_q, state_d;

  hmlp_func_e              func_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [VALUE_BITS-1:0]   val_q;
  logic [INDEX_BITS-1:0]   addr_q, addr_d;
  logic [INDEX_BITS-1:0]   probe_q, probe_d;
  logic [CountW-1:0]       count_q, count_d;
  logic [63:0]             salt_q;
  logic                    respond_q;
  hmlp_rsp_t               rsp_q, rsp_d;
  logic                    done_q, done_d;

  logic                    accept;
  logic [INDEX_BITS-1:0]   home;
  logic                    ram_we;
  logic [INDEX_BITS-1:0]   ram_raddr;
  logic [RowW-1:0]         ram_wdata;
  logic [RowW-1:0]         ram_rdata;

  logic                    row_valid;
  logic [KEY_BITS-1:0]     row_key;
  logic [VALUE_BITS-1:0]   row_val;
  logic                    hit;
  logic                    last_probe;
  logic                    resolve;
  logic [VALUE_BITS-1:0]   new_val;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  hmlp_hash #(
    .INDEX_BITS (INDEX_BITS),
    .KEY_BITS   (KEY_BITS)
  ) u_hash (
    .clk_i  (clk_i),
    .key_i  (KEY_BITS'(req_i.key)),
    .salt_i (salt_q[INDEX_BITS-1:0]),
    .home_o (home)
  );

  hmlp_slot_ram #(
    .ADDR_BITS (INDEX_BITS),
    .DATA_BITS (RowW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign row_valid  = ram_rdata[RowW-1];
  assign row_key    = ram_rdata[VALUE_BITS +: KEY_BITS];
  assign row_val    = ram_rdata[VALUE_BITS-1:0];
  assign hit        = row_valid && (row_key == key_q);
  assign last_probe = (probe_q == '1);
  assign resolve    = !row_valid || hit || last_probe;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (addr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_HASH;
      end
      ST_HASH: begin
        case (func_q)
          FUNC_SET, FUNC_ADD, FUNC_GET, FUNC_ERASE: state_d = ST_CHECK;
          FUNC_CLEAR:                               state_d = ST_CLEAR;
          default:                                  state_d = ST_IDLE;
        endcase
      end
      ST_CHECK: begin
        if (resolve) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    addr_d    = addr_q;
    probe_d   = probe_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_raddr = addr_q + 1'b1;
    done_d    = 1'b0;
    new_val   = (func_q == FUNC_ADD) ? row_val + val_q : val_q;
    rsp_d     = rsp_q;

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == '1) begin
          count_d = '0;
          done_d  = respond_q;
          rsp_d   = '0;
        end
      end
      ST_IDLE: begin
        addr_d = '0;
      end
      ST_HASH: begin
        ram_raddr = home;
        // the clear sweep has to start at slot 0
        addr_d    = (func_q == FUNC_CLEAR) ? '0 : home;
        probe_d   = '0;
        if (func_q != FUNC_SET && func_q != FUNC_ADD && func_q != FUNC_GET &&
            func_q != FUNC_ERASE && func_q != FUNC_CLEAR) begin
          done_d         = 1'b1;
          rsp_d          = '0;
          rsp_d.size_now = SizeW'(count_q);
        end
      end
      ST_CHECK: begin
        if (resolve) begin
          done_d = 1'b1;
          rsp_d  = '0;
          rsp_d.found = hit;
          case (func_q)
            FUNC_SET, FUNC_ADD: begin
              if (hit) begin
                ram_we          = 1'b1;
                ram_wdata       = {1'b1, key_q, new_val};
                rsp_d.value_out = ValW'(new_val);
              end else if (!row_valid) begin
                ram_we          = 1'b1;
                ram_wdata       = {1'b1, key_q, val_q};
                count_d         = count_q + 1'b1;
                rsp_d.value_out = ValW'(val_q);
              end else begin
                rsp_d.table_full = 1'b1;
              end
            end
            FUNC_GET: begin
              if (hit) rsp_d.value_out = ValW'(row_val);
            end
            FUNC_ERASE: begin
              if (hit) begin
                ram_we  = 1'b1;
                count_d = count_q - 1'b1;
              end
            end
            default: ;
          endcase
          rsp_d.size_now = SizeW'(count_d);
        end else begin
          addr_d  = addr_q + 1'b1;
          probe_d = probe_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      addr_q    <= '0;
      probe_q   <= '0;
      count_q   <= '0;
      salt_q    <= SaltReset;
      respond_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      probe_q <= probe_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) salt_q <= cfg_wdata_i;
      if (accept) respond_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      func_q <= req_i.func;
      key_q  <= KEY_BITS'(req_i.key);
      val_q  <= VALUE_BITS'(req_i.value_in);
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### design/hmlp_checker.sv
// Port-level checks for hash_map_linear_probe, attached by bind.
// Depends on hmlp_pkg.
module hmlp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input hmlp_pkg::hmlp_rsp_t rsp_o
);
  import hmlp_pkg::*;

  // Every transaction passes through at least one busy cycle before its result.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without preceding busy cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result strobes");

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.table_full) |-> (!rsp_o.found && rsp_o.value_out == '0))
    else $error("full result carries found or value");

endmodule

bind hash_map_linear_probe hmlp_checker u_hmlp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

### dv/tb.sv
// Self-checking testbench for hash_map_linear_probe: directed table, then random traffic and a full-table fill.
// Keeps its own mirror of the slot table and checks every result in order.
// Depends on hmlp_pkg and the hash_map_linear_probe RTL.
module tb;
  import hmlp_pkg::*;

  localparam int unsigned IdxW  = 10;
  localparam int unsigned Slots = 1 << IdxW;
  // longest quiet stretch: a clear sweep plus a full-table scan
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned DrainCycles = 2 * Slots + 16;
  localparam int unsigned IdleSlowEnd = 650;
  localparam int unsigned IdleFastEnd = 1300;
  localparam int unsigned IdleLowPct  = 8;
  localparam int unsigned IdleHighPct = 69;

  // func codes with no operation behind them
  localparam hmlp_func_e FUNC_RSVD_LO = hmlp_func_e'(3'd5);
  localparam hmlp_func_e FUNC_RSVD_MID = hmlp_func_e'(3'd6);
  localparam hmlp_func_e FUNC_RSVD_HI = hmlp_func_e'(3'd7);

  localparam logic [63:0] SaltOne     = 64'd1;
  localparam logic [63:0] SaltOnes    = '1;
  // low key bits never reach the slot index: every key lands on slot 0
  localparam logic [63:0] SaltTopOnly = 64'h8000_0000_0000_0000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  hmlp_req_t           req_drv = '0;
  logic                done_o;
  hmlp_rsp_t           rsp_mon;
  logic                cfg_we = 1'b0;
  logic [63:0]         cfg_wdata = '0;

  always #1 clk_i = ~clk_i;

  hash_map_linear_probe dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_drv),
    .done_o      (done_o),
    .rsp_o       (rsp_mon),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // mirror of the table
  logic [63:0]         mirror_salt = SaltReset;
  bit                  mirror_used [Slots];
  logic [KeyW-1:0]     mirror_key [Slots];
  logic [ValW-1:0]     mirror_val [Slots];
  int unsigned         mirror_count = 0;
  int unsigned         peak_count = 0;

  hmlp_rsp_t           expected_rsp [$];
  hmlp_rsp_t           want;
  int unsigned         fail_count = 0;
  int unsigned         sent_count = 0;
  int unsigned         checked_count = 0;
  int unsigned         stall_cycles = 0;

  typedef struct packed {
    hmlp_req_t req;
    logic      typed;
    hmlp_rsp_t rsp;
  } dir_row_t;

  localparam int unsigned DirN = 19;
  localparam logic [63:0] KeyOnes = '1;

  dir_row_t dir_rows [DirN] = '{
    '{'{FUNC_GET,      64'd0,   32'h0},         1'b1, '{32'h0,         1'b0, 11'd0, 1'b0}},
    '{'{FUNC_ERASE,    KeyOnes, 32'h0},         1'b1, '{32'h0,         1'b0, 11'd0, 1'b0}},
    '{'{FUNC_SET,      64'd0,   32'h7FFF_FFFF}, 1'b1, '{32'h7FFF_FFFF, 1'b0, 11'd1, 1'b0}},
    '{'{FUNC_ADD,      64'd0,   32'h1},         1'b1, '{32'h8000_0000, 1'b1, 11'd1, 1'b0}},
    '{'{FUNC_SET,      KeyOnes, 32'h8000_0000}, 1'b1, '{32'h8000_0000, 1'b0, 11'd2, 1'b0}},
    '{'{FUNC_ADD,      KeyOnes, 32'hFFFF_FFFF}, 1'b1, '{32'h7FFF_FFFF, 1'b1, 11'd2, 1'b0}},
    '{'{FUNC_GET,      64'd0,   32'h0},         1'b1, '{32'h8000_0000, 1'b1, 11'd2, 1'b0}},
    '{'{FUNC_ADD,      64'd5,   32'hFFFF_FFFB}, 1'b1, '{32'hFFFF_FFFB, 1'b0, 11'd3, 1'b0}},
    '{'{FUNC_RSVD_LO,  64'd5,   32'h1},         1'b1, '{32'h0,         1'b0, 11'd3, 1'b0}},
    '{'{FUNC_RSVD_HI,  KeyOnes, 32'h8000_0000}, 1'b1, '{32'h0,         1'b0, 11'd3, 1'b0}},
    '{'{FUNC_SET,      64'd5,   32'h0},         1'b1, '{32'h0,         1'b1, 11'd3, 1'b0}},
    '{'{FUNC_GET,      KeyOnes, 32'h0},         1'b1, '{32'h7FFF_FFFF, 1'b1, 11'd3, 1'b0}},
    '{'{FUNC_ERASE,    64'd0,   32'h0},         1'b1, '{32'h0,         1'b1, 11'd2, 1'b0}},
    '{'{FUNC_GET,      64'd0,   32'h0},         1'b1, '{32'h0,         1'b0, 11'd2, 1'b0}},
    '{'{FUNC_ERASE,    64'd0,   32'h0},         1'b1, '{32'h0,         1'b0, 11'd2, 1'b0}},
    // key 5 may sit behind the freed slot, so leave it to the mirror
    '{'{FUNC_GET,      64'd5,   32'h0},         1'b0, '0},
    '{'{FUNC_RSVD_MID, 64'd5,   32'hFFFF_FFFF}, 1'b0, '0},
    '{'{FUNC_CLEAR,    KeyOnes, 32'hFFFF_FFFF}, 1'b1, '{32'h0,         1'b0, 11'd0, 1'b0}},
    '{'{FUNC_GET,      64'd5,   32'h0},         1'b1, '{32'h0,         1'b0, 11'd0, 1'b0}}
  };

  // Applies one operation to the mirror and returns the result it gives.
  function automatic hmlp_rsp_t predict_table_op(hmlp_req_t r);
    logic [63:0]     mix;
    logic [63:0]     prod;
    logic [IdxW-1:0] idx;
    int unsigned     n;
    bit              slot_ok;
    bit              hit;
    hmlp_rsp_t       o;
    o = '0;
    if (r.func <= FUNC_ERASE) begin
      mix = r.key ^ (r.key >> MixShift);
      prod = mix * mirror_salt;
      idx = prod[IdxW-1:0];
      n = 0;
      while (n < Slots && mirror_used[idx] && mirror_key[idx] != r.key) begin
        idx = idx + 1'b1;
        n++;
      end
      slot_ok = (n < Slots);
      hit = slot_ok && mirror_used[idx];
      o.found = hit;
      case (r.func)
        FUNC_SET, FUNC_ADD: begin
          if (!slot_ok) begin
            o.table_full = 1'b1;
          end else if (hit) begin
            mirror_val[idx] = (r.func == FUNC_SET) ? r.value_in : mirror_val[idx] + r.value_in;
            o.value_out = mirror_val[idx];
          end else begin
            mirror_used[idx] = 1'b1;
            mirror_key[idx] = r.key;
            mirror_val[idx] = r.value_in;
            mirror_count++;
            o.value_out = r.value_in;
          end
        end
        FUNC_GET: begin
          if (hit) o.value_out = mirror_val[idx];
        end
        default: begin
          if (hit) begin
            mirror_used[idx] = 1'b0;
            mirror_count--;
          end
        end
      endcase
    end else if (r.func == FUNC_CLEAR) begin
      foreach (mirror_used[i]) mirror_used[i] = 1'b0;
      mirror_count = 0;
    end
    if (mirror_count > peak_count) peak_count = mirror_count;
    o.size_now = SizeW'(mirror_count);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    $display("mismatch at result %0d: %s got %0h, want %0h", checked_count, what, got, exp_val);
    fail_count++;
  endtask

  // Sends one transaction and queues the result it should produce.
  task automatic issue_op(hmlp_req_t r, bit typed, hmlp_rsp_t typed_rsp);
    hmlp_rsp_t   predicted;
    int unsigned idle_pct;
    idle_pct = sent_count < IdleSlowEnd ? IdleLowPct :
               sent_count < IdleFastEnd ? IdleHighPct : 0;
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_drv <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = predict_table_op(r);
    expected_rsp.push_back(typed ? typed_rsp : predicted);
    sent_count++;
  endtask

  task automatic send_op(hmlp_func_e f, logic [63:0] k, logic [31:0] v);
    hmlp_req_t r;
    r.func = f;
    r.key = k;
    r.value_in = v;
    issue_op(r, 1'b0, '0);
  endtask

  // Holds off new transactions until every queued result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_salt(logic [63:0] s);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    mirror_salt = s;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(15, 0))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Random traffic over a small pool of keys so most operations hit live entries.
  task automatic run_pool(int unsigned n_items, int unsigned pool_n);
    logic [63:0] pool [32];
    int unsigned pick;
    logic [63:0] k;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < 32; i++) pool[i] = {$urandom, $urandom};
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(99, 0) == 0) drain_results();
      pick = $urandom_range(99, 0);
      k = pool[$urandom_range(pool_n - 1, 0)];
      if (pick < 30)      send_op(FUNC_SET, k, rand_value());
      else if (pick < 55) send_op(FUNC_ADD, k, rand_value());
      else if (pick < 80) send_op(FUNC_GET, k, rand_value());
      else if (pick < 93) send_op(FUNC_ERASE, k, rand_value());
      else if (pick < 94) send_op(FUNC_CLEAR, k, rand_value());
      else if (pick < 97)
        send_op(hmlp_func_e'($urandom_range(FUNC_RSVD_HI, FUNC_RSVD_LO)), k, rand_value());
      else
        send_op(FUNC_SET, {$urandom, $urandom}, rand_value());
    end
  endtask

  // With a salt of one, key k homes to slot k: fill every slot, then probe a full table.
  task automatic run_fill();
    for (int unsigned k = 0; k < Slots; k++)
      send_op($urandom_range(1, 0) ? FUNC_ADD : FUNC_SET, 64'(k), rand_value());
    send_op(FUNC_SET, 64'(Slots), rand_value());
    send_op(FUNC_ADD, 64'(Slots + 7), rand_value());
    send_op(FUNC_GET, 64'd3, 32'h0);
    send_op(FUNC_ADD, 64'(Slots - 1), rand_value());
    send_op(FUNC_SET, 64'd5, rand_value());
    send_op(FUNC_ERASE, 64'd500, 32'h0);
    send_op(FUNC_GET, 64'(Slots + 500), 32'h0);
    send_op(FUNC_SET, 64'(Slots + 500), rand_value());
    send_op(FUNC_SET, 64'(Slots + 1000), rand_value());
    // whole table scanned without a match
    send_op(FUNC_GET, 64'd500, 32'h0);
    send_op(FUNC_ERASE, 64'd3, 32'h0);
    send_op(FUNC_GET, 64'd3, 32'h0);
    send_op(FUNC_ADD, 64'd3, rand_value());
    send_op(FUNC_CLEAR, 64'd0, 32'h0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected result", {32'h0, rsp_mon.value_out}, 64'd0);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_mon.value_out !== want.value_out)
          report_mismatch("value_out", {32'h0, rsp_mon.value_out}, {32'h0, want.value_out});
        if (rsp_mon.found !== want.found)
          report_mismatch("found", 64'(rsp_mon.found), 64'(want.found));
        if (rsp_mon.size_now !== want.size_now)
          report_mismatch("size_now", 64'(rsp_mon.size_now), 64'(want.size_now));
        if (rsp_mon.table_full !== want.table_full)
          report_mismatch("table_full", 64'(rsp_mon.table_full), 64'(want.table_full));
        checked_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               StallLimit, expected_rsp.size());
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [63:0] salt_pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirN; i++)
      issue_op(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    run_pool(300, 24);
    write_salt(SaltOnes);
    run_pool(300, 24);
    write_salt(SaltOne);
    run_fill();
    write_salt(SaltTopOnly);
    run_pool(150, 12);
    salt_pick = {$urandom, $urandom};
    if (salt_pick == '0) salt_pick = SaltOne;
    write_salt(salt_pick);
    run_pool(150, 24);

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("summary: %0d transactions, %0d results checked, %0d mismatches",
             sent_count, checked_count, fail_count);
    $display("summary: five salts incl. 1 and all-ones, peak occupancy %0d of %0d slots",
             peak_count, Slots);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### hash_map_linear_probe.f
design/hmlp_pkg.sv
design/hmlp_hash.sv
design/hmlp_slot_ram.sv
design/hash_map_linear_probe.sv
design/hmlp_checker.sv
dv/tb.sv
